### design/pldt_pkg.sv
// shared types and constants for the packet log dedup table
package pldt_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int ROW_TOTAL_W      = 9;
   localparam int HITS_W           = 32;

   typedef enum logic [1:0] {
      OP_LOG    = 2'd0,
      OP_READ   = 2'd1,
      OP_REWIND = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_NEW     = 3'd0,
      STATUS_MERGED  = 3'd1,
      STATUS_DROPPED = 3'd2,
      STATUS_ROW     = 3'd3,
      STATUS_END     = 3'd4,
      STATUS_DONE    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_HIT,
      S_APPEND,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [31:0]        now_time;
      logic [7:0]         protocol;
      logic [7:0]         action;
      logic [7:0]         hook;
      logic [31:0]        src_ip;
      logic [31:0]        dst_ip;
      logic [15:0]        sport;
      logic [15:0]        dport;
      logic signed [31:0] reason;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [31:0]             out_time;
      logic [7:0]              out_protocol;
      logic [7:0]              out_action;
      logic [7:0]              out_hook;
      logic [31:0]             out_src_ip;
      logic [31:0]             out_dst_ip;
      logic [15:0]             out_sport;
      logic [15:0]             out_dport;
      logic signed [31:0]      out_reason;
      logic [31:0]             out_count;
      logic [ROW_TOTAL_W-1:0]  row_total;
   } rsp_type;

   // eight-field match key of one row
   typedef struct packed {
      logic [7:0]         protocol;
      logic [7:0]         action;
      logic [7:0]         hook;
      logic [31:0]        src_ip;
      logic [31:0]        dst_ip;
      logic [15:0]        sport;
      logic [15:0]        dport;
      logic signed [31:0] reason;
   } key_type;

   typedef struct packed {
      key_type             key;
      logic [31:0]         seen_time;
      logic [HITS_W-1:0]   hits;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // result of the shared key compare unit
   typedef struct packed {
      logic              match;
      logic [HITS_W-1:0] hits_next;
   } cmp_res_type;

endpackage

### design/pldt_ram.sv
// generic single write, single read ram with registered read data
module pldt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pldt_keycmp.sv
// shared key compare and saturating hit increment unit
module pldt_keycmp import pldt_pkg::*; (
   input  row_type     row,
   input  key_type     key,
   output cmp_res_type res
);

   always_comb begin
      res.match     = (row.key == key);
      res.hits_next = (row.hits == {HITS_W{1'b1}}) ? row.hits : row.hits + HITS_W'(1);
   end

endmodule

### design/packet_log_dedup_table.sv
// packet log table: searches, merges, appends and reads back rows kept in one ram; also rewinds and clears
// throughput: one transaction at a time; the next request is taken the cycle after the
//   response is loaded; a stalled output register can hold the sequencer in its
//   response state
// reset: row count, read position and handshake state clear; row ram is not cleared
module packet_log_dedup_table import pldt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // sequencer state
   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   status_type        status_ff, status_in;

   // table bookkeeping
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;

   // scan pipeline: issue index and the row whose read data is pending
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // ram ports
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   row_type           wr_row;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ROW_W-1:0]  rd_bits;
   row_type           rd_row;

   key_type           req_key;
   cmp_res_type       cmp;

   assign rd_row = row_type'(rd_bits);

   assign req_key = '{protocol: req_ff.protocol, action: req_ff.action, hook: req_ff.hook,
                      src_ip: req_ff.src_ip, dst_ip: req_ff.dst_ip,
                      sport: req_ff.sport, dport: req_ff.dport,
                      reason: req_ff.reason};

   pldt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CAPACITY)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ROW_W'(wr_row)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   // one comparator serves every row of the scan and the merge update
   pldt_keycmp u_keycmp (
      .row (rd_row),
      .key (req_key),
      .res (cmp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan bookkeeping need no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      status_ff   <= status_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      hit_idx_ff  <= hit_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      rsp_type rsp_next;

      state_in     = state_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      hit_idx_in   = hit_idx_ff;
      rsp_data_in  = rsp_data_ff;
      // output register drains when the consumer takes the transaction
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_row       = '{key: req_key, seen_time: req_ff.now_time, hits: HITS_W'(1)};
      rd_en        = 1'b0;
      rd_addr      = scan_ff[IDX_W-1:0];

      // response built from the final status; row fields only for a returned row
      rsp_next           = '0;
      rsp_next.status    = status_ff;
      rsp_next.row_total = ROW_TOTAL_W'(count_ff);
      if (status_ff == STATUS_ROW) begin
         rsp_next.out_time     = rd_row.seen_time;
         rsp_next.out_protocol = rd_row.key.protocol;
         rsp_next.out_action   = rd_row.key.action;
         rsp_next.out_hook     = rd_row.key.hook;
         rsp_next.out_src_ip   = rd_row.key.src_ip;
         rsp_next.out_dst_ip   = rd_row.key.dst_ip;
         rsp_next.out_sport    = rd_row.key.sport;
         rsp_next.out_dport    = rd_row.key.dport;
         rsp_next.out_reason   = rd_row.key.reason;
         rsp_next.out_count    = rd_row.hits;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               unique case (req_data.op)
                  OP_LOG: begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
                  OP_READ: begin
                     state_in = S_READ;
                  end
                  OP_REWIND: begin
                     pos_in    = '0;
                     status_in = STATUS_DONE;
                     state_in  = S_RESP;
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     pos_in    = '0;
                     status_in = STATUS_DONE;
                     state_in  = S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (pend_ff && cmp.match) begin
               // hold the read data so the merge sees the matching row
               hit_idx_in = pend_idx_ff;
               state_in   = S_HIT;
            end else if (scan_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = S_APPEND;
            end
         end
         S_HIT: begin
            wr_en     = 1'b1;
            wr_addr   = hit_idx_ff;
            wr_row    = '{key: rd_row.key, seen_time: req_ff.now_time, hits: cmp.hits_next};
            status_in = STATUS_MERGED;
            state_in  = S_RESP;
         end
         S_APPEND: begin
            if (count_ff != CNT_W'(CAPACITY)) begin
               wr_en     = 1'b1;
               wr_addr   = count_ff[IDX_W-1:0];
               count_in  = count_ff + CNT_W'(1);
               status_in = STATUS_NEW;
            end else begin
               status_in = STATUS_DROPPED;
            end
            state_in = S_RESP;
         end
         S_READ: begin
            if (pos_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = pos_ff[IDX_W-1:0];
               pos_in    = pos_ff + CNT_W'(1);
               status_in = STATUS_ROW;
            end else begin
               status_in = STATUS_END;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // wait for a free output register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rsp_next;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/pldt_checker.sv
// port-level checker for the packet log dedup table and its bind
module pldt_checker import pldt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // row total never beyond capacity
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.row_total) <= 32'(CAPACITY)))
      else $error("row total beyond capacity");

   // only a returned row carries row fields
   a_rowless_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_ROW) |->
         (rsp_data.out_count == '0) && (rsp_data.out_time == '0) &&
         (rsp_data.out_src_ip == '0) && (rsp_data.out_reason == '0))
      else $error("row fields set without a returned row");

   // every stored row has been hit at least once
   a_row_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_ROW) |-> (rsp_data.out_count != '0))
      else $error("returned row with zero count");

endmodule

bind packet_log_dedup_table pldt_checker #(.CAPACITY(CAPACITY)) u_pldt_checker (.*);
